// ----- rtl/key_matrix_debounce_scanner_macros.svh -----
// assertion helpers used by the checker file
`ifndef KEY_MATRIX_DEBOUNCE_SCANNER_MACROS_SVH
`define KEY_MATRIX_DEBOUNCE_SCANNER_MACROS_SVH

// clocked assertion, switched off while reset is high
`define KMDS_ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion, checked through reset too
`define KMDS_ASSERT(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/kmds_pkg.sv -----
`timescale 1ns / 1ps

package kmds_pkg;

   localparam int ROW_COUNT_DEFAULT = 16;
   localparam int COL_COUNT_DEFAULT = 8;

   localparam int ROW_BITS_W = 16;
   localparam int COLUMN_W   = 3;
   localparam int QUERY_W    = 4;
   localparam int KEYS_W     = 8;
   localparam int COUNT_W    = 8;
   localparam int DEBOUNCE_W = 8;

   localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 8'd10;

   localparam logic REQ_SAMPLE   = 1'b0;
   localparam logic REQ_END_PASS = 1'b1;

   typedef struct packed {
      logic                  req_type;
      logic [COLUMN_W-1:0]   column;
      logic [ROW_BITS_W-1:0] row_bits;
      logic [QUERY_W-1:0]    query_row;
   } item_type;

   typedef struct packed {
      logic               settled;
      logic [KEYS_W-1:0]  row_keys;
      logic               row_ghost;
      logic [COUNT_W-1:0] key_count;
   } result_type;

endpackage

// ----- rtl/kmds_matrix.sv -----
`timescale 1ns / 1ps

module kmds_matrix #(
   parameter int ROW_COUNT = kmds_pkg::ROW_COUNT_DEFAULT,
   parameter int COL_COUNT = kmds_pkg::COL_COUNT_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                fire,
   input  kmds_pkg::item_type                  item,
   input  logic [kmds_pkg::DEBOUNCE_W-1:0]     debounce,
   output kmds_pkg::result_type                result
);

   localparam int RowWide = (ROW_COUNT > kmds_pkg::ROW_BITS_W) ? ROW_COUNT
                                                              : kmds_pkg::ROW_BITS_W;
   localparam int KeyWide = (COL_COUNT > kmds_pkg::KEYS_W) ? COL_COUNT : kmds_pkg::KEYS_W;
   localparam int CountW  = $clog2(ROW_COUNT * COL_COUNT + 1);
   localparam int CntWide = (CountW > kmds_pkg::COUNT_W) ? CountW : kmds_pkg::COUNT_W;

   logic [COL_COUNT-1:0]            raw_ff [ROW_COUNT];
   logic [COL_COUNT-1:0]            raw_in [ROW_COUNT];
   logic [COL_COUNT-1:0]            stable_ff [ROW_COUNT];
   logic [COL_COUNT-1:0]            stable_in [ROW_COUNT];
   logic [kmds_pkg::DEBOUNCE_W-1:0] quiet_ff, quiet_in;
   logic [CountW-1:0]               raw_count_ff, raw_count_in;
   logic [CountW-1:0]               stable_count_ff, stable_count_in;

   logic [COL_COUNT-1:0]            col_sel;
   logic [RowWide-1:0]              row_ext;
   logic [ROW_COUNT-1:0]            row_old, row_new;
   logic                            is_sample, changed, copy;
   logic [kmds_pkg::DEBOUNCE_W-1:0] reload;

   logic [ROW_COUNT-1:0]            col_rows [COL_COUNT];
   logic [COL_COUNT-1:0]            multi;
   logic [COL_COUNT-1:0]            sel_row;
   logic [KeyWide-1:0]              sel_ext;
   logic [CntWide-1:0]              count_ext;

   // state update
   always_comb begin
      for (int c = 0; c < COL_COUNT; c++) begin
         col_sel[c] = (32'(item.column) == 32'(c));
      end
      row_ext   = RowWide'(item.row_bits);
      is_sample = (item.req_type == kmds_pkg::REQ_SAMPLE);
      for (int r = 0; r < ROW_COUNT; r++) begin
         row_old[r] = |(raw_ff[r] & col_sel);
      end
      row_new = (|col_sel) ? row_ext[ROW_COUNT-1:0] : '0;
      changed = is_sample && (row_old != row_new);

      for (int r = 0; r < ROW_COUNT; r++) begin
         raw_in[r] = is_sample ? ((raw_ff[r] & ~col_sel) | (row_new[r] ? col_sel : '0))
                               : raw_ff[r];
      end
      raw_count_in = is_sample ? (raw_count_ff - CountW'($countones(row_old))
                                  + CountW'($countones(row_new)))
                               : raw_count_ff;

      reload   = (debounce == '0) ? kmds_pkg::DEBOUNCE_W'(1) : debounce;
      quiet_in = quiet_ff;
      copy     = 1'b0;
      if (changed) begin
         quiet_in = reload;
      end else if (!is_sample && quiet_ff != '0) begin
         quiet_in = quiet_ff - kmds_pkg::DEBOUNCE_W'(1);
         copy     = (quiet_ff == kmds_pkg::DEBOUNCE_W'(1));
      end

      for (int r = 0; r < ROW_COUNT; r++) begin
         stable_in[r] = copy ? raw_ff[r] : stable_ff[r];
      end
      stable_count_in = copy ? raw_count_ff : stable_count_ff;
   end

   // result from the updated stable matrix
   always_comb begin
      for (int c = 0; c < COL_COUNT; c++) begin
         for (int r = 0; r < ROW_COUNT; r++) begin
            col_rows[c][r] = stable_in[r][c];
         end
         multi[c] = |(col_rows[c] & (col_rows[c] - ROW_COUNT'(1)));
      end
      sel_row = '0;
      for (int r = 0; r < ROW_COUNT; r++) begin
         if (32'(item.query_row) == 32'(r)) begin
            sel_row = stable_in[r];
         end
      end
      sel_ext   = KeyWide'(sel_row);
      count_ext = CntWide'(stable_count_in);

      result.settled   = (quiet_in == '0);
      result.row_keys  = sel_ext[kmds_pkg::KEYS_W-1:0];
      result.row_ghost = (|(sel_row & (sel_row - COL_COUNT'(1)))) && (|(sel_row & multi));
      result.key_count = (count_ext > CntWide'(255)) ? '1 : count_ext[kmds_pkg::COUNT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < ROW_COUNT; r++) begin
            raw_ff[r]    <= '0;
            stable_ff[r] <= '0;
         end
         quiet_ff        <= kmds_pkg::DEBOUNCE_RESET;
         raw_count_ff    <= '0;
         stable_count_ff <= '0;
      end else if (fire) begin
         for (int r = 0; r < ROW_COUNT; r++) begin
            raw_ff[r]    <= raw_in[r];
            stable_ff[r] <= stable_in[r];
         end
         quiet_ff        <= quiet_in;
         raw_count_ff    <= raw_count_in;
         stable_count_ff <= stable_count_in;
      end
   end

endmodule

// ----- rtl/key_matrix_debounce_scanner.sv -----
`timescale 1ns / 1ps
// channel   direction  handshake              payload
// req_      in         req_valid / req_stall  req_type, column, row_bits, query_row
// rsp_      out        rsp_valid / rsp_stall  settled, row_keys, row_ghost, key_count
// csr_      in         csr_wr_en              csr_wr_data (debounce scans)
//
// one transaction per clock unless rsp_stall holds a result; a result becomes valid
// once its request has passed the input register, then the result register
// synchronous active-high reset clears both matrices, loads the quiet counter
// and the debounce register with 10
// req_stall rises only while a result is held by rsp_stall and the input
// register is full

module key_matrix_debounce_scanner #(
   parameter int ROW_COUNT = kmds_pkg::ROW_COUNT_DEFAULT,
   parameter int COL_COUNT = kmds_pkg::COL_COUNT_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_type,
   input  logic [kmds_pkg::COLUMN_W-1:0]       req_column,
   input  logic [kmds_pkg::ROW_BITS_W-1:0]     req_row_bits,
   input  logic [kmds_pkg::QUERY_W-1:0]        req_query_row,

   input  logic                                csr_wr_en,
   input  logic [kmds_pkg::DEBOUNCE_W-1:0]     csr_wr_data,

   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_settled,
   output logic [kmds_pkg::KEYS_W-1:0]         rsp_row_keys,
   output logic                                rsp_row_ghost,
   output logic [kmds_pkg::COUNT_W-1:0]        rsp_key_count
);

   logic                            s1_valid_ff, s1_valid_in;
   kmds_pkg::item_type              s1_item_ff;
   logic                            rsp_valid_ff, rsp_valid_in;
   kmds_pkg::result_type            rsp_result_ff;
   kmds_pkg::result_type            result;
   logic [kmds_pkg::DEBOUNCE_W-1:0] debounce_ff;
   logic                            out_hold, advance, fire, req_accept;

   assign out_hold   = rsp_valid_ff && rsp_stall;
   assign advance    = !out_hold;
   assign fire       = s1_valid_ff && advance;
   assign req_stall  = s1_valid_ff && out_hold;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      s1_valid_in  = req_stall ? s1_valid_ff : req_valid;
      rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;
   end

   kmds_matrix #(
      .ROW_COUNT (ROW_COUNT),
      .COL_COUNT (COL_COUNT)
   ) u_matrix (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .item     (s1_item_ff),
      .debounce (debounce_ff),
      .result   (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         debounce_ff  <= kmds_pkg::DEBOUNCE_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            debounce_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_item_ff.req_type  <= req_type;
         s1_item_ff.column    <= req_column;
         s1_item_ff.row_bits  <= req_row_bits;
         s1_item_ff.query_row <= req_query_row;
      end
      if (fire) begin
         rsp_result_ff <= result;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_settled   = rsp_result_ff.settled;
   assign rsp_row_keys  = rsp_result_ff.row_keys;
   assign rsp_row_ghost = rsp_result_ff.row_ghost;
   assign rsp_key_count = rsp_result_ff.key_count;

endmodule

// ----- rtl/kmds_checker.sv -----
`timescale 1ns / 1ps
`include "key_matrix_debounce_scanner_macros.svh"

module kmds_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_stall,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic                        rsp_settled,
   input logic [kmds_pkg::KEYS_W-1:0]  rsp_row_keys,
   input logic                        rsp_row_ghost,
   input logic [kmds_pkg::COUNT_W-1:0] rsp_key_count
);

   `KMDS_ASSERT(a_reset_clears, clock, reset |=> !rsp_valid && !req_stall, "reset left a transaction")
   `KMDS_ASSERT(a_stall_cause, clock, req_stall |-> rsp_valid && rsp_stall, "req_stall without held result")
   `KMDS_ASSERT_RST(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_settled) && $stable(rsp_row_keys) && $stable(rsp_row_ghost) && $stable(rsp_key_count), "stalled result changed")
   `KMDS_ASSERT_RST(a_ghost_keys, clock, reset, rsp_valid && rsp_row_ghost |-> $countones(rsp_row_keys) >= 2, "ghost flag on row with fewer than two keys")
   `KMDS_ASSERT_RST(a_count_cover, clock, reset, rsp_valid |-> $countones(rsp_row_keys) <= rsp_key_count, "row keys exceed total count")

endmodule

bind key_matrix_debounce_scanner kmds_checker u_kmds_checker (.*);

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

   class scan_status_scoreboard;
      logic [7:0] raw_rows[16];
      logic [7:0] stable_rows[16];
      logic [7:0] quiet_count;
      logic [7:0] debounce_setting;
      kmds_pkg::result_type expected_status_q[$];
      int errors;

      function new();
         for (int r = 0; r < 16; r++) begin
            raw_rows[r] = '0;
            stable_rows[r] = '0;
         end
         quiet_count = 8'd10;
         debounce_setting = 8'd10;
         errors = 0;
      endfunction

      function void set_debounce(logic [7:0] value);
         debounce_setting = value;
      endfunction

      function int pending();
         return expected_status_q.size();
      endfunction

      function void note_scan_item(kmds_pkg::item_type it);
         kmds_pkg::result_type want;
         int total;
         logic [7:0] col_bit;
         logic [7:0] reload;
         reload = (debounce_setting == 8'd0) ? 8'd1 : debounce_setting;
         if (it.req_type == kmds_pkg::REQ_SAMPLE) begin
            col_bit = 8'd1 << it.column;
            for (int r = 0; r < 16; r++) begin
               if ((it.row_bits[r] == 1'b1) != ((raw_rows[r] & col_bit) != 8'd0)) begin
                  raw_rows[r] ^= col_bit;
                  quiet_count = reload;
               end
            end
         end else if (quiet_count != 8'd0) begin
            quiet_count--;
            if (quiet_count == 8'd0)
               stable_rows = raw_rows;
         end
         total = 0;
         for (int r = 0; r < 16; r++)
            total += $countones(stable_rows[r]);
         if (total > 255)
            total = 255;
         want.settled = (quiet_count == 8'd0);
         want.row_keys = stable_rows[it.query_row];
         want.row_ghost = 1'b0;
         if ($countones(want.row_keys) >= 2) begin
            for (int r = 0; r < 16; r++) begin
               if (r != it.query_row && (stable_rows[r] & want.row_keys) != 8'd0)
                  want.row_ghost = 1'b1;
            end
         end
         want.key_count = 8'(total);
         expected_status_q.push_back(want);
      endfunction

      function void check_scan_status(kmds_pkg::result_type got);
         kmds_pkg::result_type want;
         if (expected_status_q.size() == 0) begin
            $display("%0t: result with none expected: settled=%0d keys=%0h ghost=%0d count=%0d",
                     $time, got.settled, got.row_keys, got.row_ghost, got.key_count);
            errors++;
            return;
         end
         want = expected_status_q.pop_front();
         if (got.settled !== want.settled) begin
            $display("%0t: settled mismatch, expected %0d actual %0d",
                     $time, want.settled, got.settled);
            errors++;
         end
         if (got.row_keys !== want.row_keys) begin
            $display("%0t: row_keys mismatch, expected %0h actual %0h",
                     $time, want.row_keys, got.row_keys);
            errors++;
         end
         if (got.row_ghost !== want.row_ghost) begin
            $display("%0t: row_ghost mismatch, expected %0d actual %0d",
                     $time, want.row_ghost, got.row_ghost);
            errors++;
         end
         if (got.key_count !== want.key_count) begin
            $display("%0t: key_count mismatch, expected %0d actual %0d",
                     $time, want.key_count, got.key_count);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic req_valid = 1'b0;
   logic req_stall;
   logic req_type = kmds_pkg::REQ_SAMPLE;
   logic [kmds_pkg::COLUMN_W-1:0] req_column = '0;
   logic [kmds_pkg::ROW_BITS_W-1:0] req_row_bits = '0;
   logic [kmds_pkg::QUERY_W-1:0] req_query_row = '0;

   logic csr_wr_en = 1'b0;
   logic [kmds_pkg::DEBOUNCE_W-1:0] csr_wr_data = '0;

   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_settled;
   logic [kmds_pkg::KEYS_W-1:0] rsp_row_keys;
   logic rsp_row_ghost;
   logic [kmds_pkg::COUNT_W-1:0] rsp_key_count;

   scan_status_scoreboard sb;
   logic [15:0] key_cols[8];
   bit gaps_on = 1'b1;
   int items_sent = 0;

   key_matrix_debounce_scanner uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_type      (req_type),
      .req_column    (req_column),
      .req_row_bits  (req_row_bits),
      .req_query_row (req_query_row),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_settled   (rsp_settled),
      .rsp_row_keys  (rsp_row_keys),
      .rsp_row_ghost (rsp_row_ghost),
      .rsp_key_count (rsp_key_count)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // result side back-pressure
   initial begin
      int run_len;
      int hold_len;
      forever begin
         if ($urandom_range(0, 99) < 10)
            run_len = $urandom_range(60, 200);
         else
            run_len = $urandom_range(1, 12);
         if ($urandom_range(0, 99) < 85)
            hold_len = $urandom_range(1, 3);
         else
            hold_len = $urandom_range(10, 40);
         rsp_stall <= 1'b0;
         repeat (run_len) @(posedge clock);
         rsp_stall <= 1'b1;
         repeat (hold_len) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0)
         sb.check_scan_status(kmds_pkg::result_type'({rsp_settled, rsp_row_keys,
                                                      rsp_row_ghost, rsp_key_count}));
   end

   function automatic int pick_gap();
      int r;
      if (!gaps_on)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      else if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic send_scan_item(input logic kind, input int col, input logic [15:0] rows,
                                 input int query);
      kmds_pkg::item_type it;
      int gap;
      it.req_type = kind;
      it.column = kmds_pkg::COLUMN_W'(col);
      it.row_bits = rows;
      it.query_row = kmds_pkg::QUERY_W'(query);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= it.req_type;
      req_column <= it.column;
      req_row_bits <= it.row_bits;
      req_query_row <= it.query_row;
      do
         @(posedge clock);
      while (req_stall !== 1'b0);
      sb.note_scan_item(it);
      items_sent++;
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_debounce(input logic [7:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.set_debounce(value);
   endtask

   task automatic end_pass_item();
      send_scan_item(kmds_pkg::REQ_END_PASS, $urandom_range(0, 7),
                     16'($urandom_range(0, 65535)), $urandom_range(0, 15));
   endtask

   // one scan over the first cols_to_scan columns; bounce flips a single sampled bit
   task automatic scan_pass(input int cols_to_scan, input int bounce_pct);
      logic [15:0] rows;
      int idx;
      for (int c = 0; c < cols_to_scan; c++) begin
         rows = key_cols[c];
         if ($urandom_range(0, 99) < bounce_pct) begin
            idx = $urandom_range(0, 15);
            rows[idx] = ~rows[idx];
         end
         send_scan_item(kmds_pkg::REQ_SAMPLE, c, rows, $urandom_range(0, 15));
      end
      end_pass_item();
   endtask

   task automatic new_key_pattern();
      for (int c = 0; c < 8; c++)
         key_cols[c] = 16'($urandom & $urandom);
   endtask

   task automatic run_phase(input logic [7:0] debounce, input int budget, input int change_pct,
                            input bit with_gaps, input bit drain_midway);
      int start;
      int pick;
      int c;
      bit drained;
      wait_for_results();
      write_debounce(debounce);
      gaps_on = with_gaps;
      new_key_pattern();
      start = items_sent;
      drained = 1'b0;
      while (items_sent - start < budget) begin
         pick = $urandom_range(0, 99);
         if (pick < 80)
            scan_pass(8, 2);
         else if (pick < 90)
            scan_pass($urandom_range(1, 7), 10);
         else
            send_scan_item(1'($urandom_range(0, 1)), $urandom_range(0, 7),
                           16'($urandom_range(0, 65535)), $urandom_range(0, 15));
         if ($urandom_range(0, 99) < change_pct) begin
            c = $urandom_range(0, 7);
            key_cols[c] ^= 16'(1 << $urandom_range(0, 15));
         end
         if (drain_midway && !drained && items_sent - start >= budget / 2) begin
            wait_for_results();
            drained = 1'b1;
         end
      end
   endtask

   initial begin
      sb = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset setting: counter starts at ten
      send_scan_item(kmds_pkg::REQ_END_PASS, 0, 16'h0000, 0);
      send_scan_item(kmds_pkg::REQ_SAMPLE, 0, 16'hFFFF, 15);
      send_scan_item(kmds_pkg::REQ_SAMPLE, 7, 16'hFFFF, 0);
      // new setting must not touch the running counter
      wait_for_results();
      write_debounce(8'd1);
      repeat (10) end_pass_item();
      send_scan_item(kmds_pkg::REQ_SAMPLE, 3, 16'h0001, 0);
      send_scan_item(kmds_pkg::REQ_END_PASS, 7, 16'hFFFF, 0);
      send_scan_item(kmds_pkg::REQ_SAMPLE, 0, 16'h0000, 15);
      send_scan_item(kmds_pkg::REQ_SAMPLE, 7, 16'h8000, 15);
      send_scan_item(kmds_pkg::REQ_END_PASS, 0, 16'h0000, 15);
      // full matrix
      for (int c = 0; c < 8; c++)
         send_scan_item(kmds_pkg::REQ_SAMPLE, c, 16'hFFFF, c * 2);
      send_scan_item(kmds_pkg::REQ_END_PASS, 5, 16'h5A5A, 9);

      run_phase(8'd0, 25, 20, 1'b1, 1'b0);
      run_phase(8'd1, 25, 25, 1'b0, 1'b1);
      run_phase(8'd2, 25, 15, 1'b1, 1'b0);
      run_phase(8'd3, 25, 10, 1'b1, 1'b0);

      // longest setting, held quiet until it settles
      wait_for_results();
      write_debounce(8'd255);
      gaps_on = 1'b1;
      new_key_pattern();
      key_cols[0] = 16'($urandom & 16'h7FFF);
      send_scan_item(kmds_pkg::REQ_SAMPLE, 0, 16'hFFFF, $urandom_range(0, 15));
      scan_pass(8, 0);
      repeat (258) end_pass_item();

      run_phase(8'($urandom_range(4, 8)), 25, 8, 1'b1, 1'b0);
      run_phase(8'd1, 25, 40, 1'b1, 1'b0);

      wait_for_results();
      repeat (10) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/kmds_pkg.sv
rtl/kmds_matrix.sv
rtl/key_matrix_debounce_scanner.sv
rtl/kmds_checker.sv
sim/tb_top.sv
